[rtl/dq_pkg.sv]
package dq_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DEL_AFTER  = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_READ_OUT   = 3'd6,
        CMD_NOP        = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NO_MATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_LEFT,
        OP_RIGHT,
        OP_FRONT
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } t_state;

    typedef struct packed {
        t_cell_op op;
        logic     pick;
        logic     valid;
        logic     cap;
    } t_cell_ctl;

endpackage

[rtl/dq_cell.sv]
module dq_cell (
    input  logic                                i_clk,
    input  dq_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_load,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_left,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_right,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_front,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_cmp,
    input  logic                                i_seen,
    output logic                                o_seen,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_acc,
    output logic signed [dq_pkg::DATA_W-1:0]    o_acc,
    output logic signed [dq_pkg::DATA_W-1:0]    o_data
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic                     r_hit;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD:  r_data <= i_load;
            OP_LEFT:  r_data <= i_left;
            OP_RIGHT: r_data <= i_right;
            OP_FRONT: r_data <= i_front;
            default:  r_data <= r_data;
        endcase
        if (i_ctl.cap) begin
            r_hit <= (r_data == i_cmp);
        end
    end

    // seen out: this cell or some earlier live cell matched
    assign o_seen = i_seen | (r_hit & i_ctl.valid);
    assign o_acc  = i_acc | (i_ctl.pick ? r_data : '0);
    assign o_data = r_data;

endmodule

[rtl/bounded_deque_with_match_delete_core.sv]
// A command is taken in the idle state and executed in the exec state, which puts its
// word in the output register once that register is free to take it.
// Read out then emits one word per cycle for each stored entry while the output keeps up,
// as the cell row rotates by one position for each word emitted.
// Reset clears the entry count, the control state and the output valid;
// cell contents are left as they are.
module bounded_deque_with_match_delete_core #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_command,
    input  logic signed [dq_pkg::DATA_W-1:0]    i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [dq_pkg::DATA_W-1:0]    o_element,
    output logic                                o_element_valid,
    output logic [CW-1:0]                       o_entry_count,
    output logic                                o_last
);
    import dq_pkg::*;

    localparam int unsigned IW = $clog2(CAPACITY);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_idx, n_idx;
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_val;

    logic                     r_ov;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_elem;
    logic                     r_ev;
    logic [CW-1:0]            r_cnt;
    logic                     r_last;

    logic                     w_accept, w_slot, w_load, w_ev, w_last, w_found;
    logic                     w_full, w_empty;
    t_status                  w_status;
    logic [CAPACITY-1:0]      w_valid, w_pick;
    t_cell_op                 w_op [CAPACITY];
    logic [CAPACITY:0]        w_seen;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_ext  [CAPACITY+2];
    logic signed [DATA_W-1:0] w_acc  [CAPACITY+1];
    t_cell_ctl                w_ctl  [CAPACITY];

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_slot     = ~r_ov | i_out_ready;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_seen[0]           = 1'b0;
    assign w_acc[0]            = '0;
    assign w_ext[0]            = r_val;
    assign w_ext[CAPACITY + 1] = w_data[CAPACITY - 1];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g]    = (CW'(g) < r_count);
        assign w_ext[g + 1]  = w_data[g];
        assign w_ctl[g]      = {w_op[g], w_pick[g], w_valid[g], w_accept};

        dq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_load  (r_val),
            .i_left  (w_ext[g]),
            .i_right (w_ext[g + 2]),
            .i_front (w_data[0]),
            .i_cmp   (i_value),
            .i_seen  (w_seen[g]),
            .o_seen  (w_seen[g + 1]),
            .i_acc   (w_acc[g]),
            .o_acc   (w_acc[g + 1]),
            .o_data  (w_data[g])
        );
    end

    always_comb begin
        w_found = 1'b0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_found = w_found | (w_seen[j] & w_valid[j]);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        w_load   = 1'b0;
        w_status = STS_OK;
        w_ev     = 1'b0;
        w_last   = 1'b1;
        w_pick   = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_op[j] = OP_HOLD;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_slot) begin
                    n_state = ST_IDLE;
                    w_load  = 1'b1;
                    case (r_cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (w_full) begin
                                w_status = STS_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (r_cmd == CMD_PUSH_FRONT) begin
                                        w_op[j] = (j == 0) ? OP_LOAD : OP_LEFT;
                                    end else if (CW'(j) == r_count) begin
                                        w_op[j] = OP_LOAD;
                                    end
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (w_empty) begin
                                w_status = STS_EMPTY;
                            end else begin
                                n_count   = r_count - 1'b1;
                                w_ev      = 1'b1;
                                w_pick[0] = 1'b1;
                                for (int j = 0; j < CAPACITY - 1; j++) begin
                                    w_op[j] = OP_RIGHT;
                                end
                            end
                        end
                        CMD_POP_BACK: begin
                            if (w_empty) begin
                                w_status = STS_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                w_ev    = 1'b1;
                                for (int j = 0; j < CAPACITY; j++) begin
                                    w_pick[j] = (CW'(j) + CW'(1) == r_count);
                                end
                            end
                        end
                        CMD_DEL_AFTER: begin
                            if (w_empty) begin
                                w_status = STS_EMPTY;
                            end else if (!w_found) begin
                                w_status = STS_NO_MATCH;
                            end else begin
                                // the successor is the first cell after the first match
                                n_count = r_count - 1'b1;
                                w_ev    = 1'b1;
                                for (int j = 1; j < CAPACITY; j++) begin
                                    w_pick[j] = w_seen[j] & ~w_seen[j - 1];
                                end
                                for (int j = 0; j < CAPACITY - 1; j++) begin
                                    if (w_seen[j]) begin
                                        w_op[j] = OP_RIGHT;
                                    end
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            w_status = w_empty ? STS_EMPTY : STS_OK;
                            n_count  = '0;
                        end
                        CMD_READ_OUT: begin
                            if (w_empty) begin
                                w_status = STS_EMPTY;
                            end else begin
                                w_load  = 1'b0;
                                n_state = ST_READ;
                                n_idx   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (w_slot) begin
                    // emit the front word and rotate it to the back
                    w_load    = 1'b1;
                    w_ev      = 1'b1;
                    w_pick[0] = 1'b1;
                    w_last    = (CW'(r_idx) + CW'(1) == r_count);
                    n_idx     = r_idx + 1'b1;
                    for (int j = 0; j < CAPACITY; j++) begin
                        if (CW'(j) + CW'(1) < r_count) begin
                            w_op[j] = OP_RIGHT;
                        end else if (CW'(j) + CW'(1) == r_count) begin
                            w_op[j] = OP_FRONT;
                        end
                    end
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_command);
            r_val <= i_value;
        end
        if (w_load) begin
            r_status <= w_status;
            r_elem   <= w_ev ? w_acc[CAPACITY] : '0;
            r_ev     <= w_ev;
            r_cnt    <= n_count;
            r_last   <= w_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_status;
    assign o_element       = r_elem;
    assign o_element_valid = r_ev;
    assign o_entry_count   = r_cnt;
    assign o_last          = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted word not executed next cycle");

    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pick))
        else $error("more than one cell drives the element");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) || (r_count == '0)
            || (r_count == $past(r_count) + 1'b1)
            || (r_count + 1'b1 == $past(r_count)))
        else $error("entry count moved by more than one");

    a_read_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && w_load && w_last) |=> (r_state == ST_IDLE && r_last))
        else $error("read out did not close with last");

endmodule
